// ===== rtl/sdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// sdspi_pkg: shared types and constants of the SD SPI command sequencer
// Holds the phase encoding, operation and status codes, register indexes and
// the structs passed between the sequencer core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

   // Data block size and derived widths
   localparam int BLOCK_BYTES  = 512;
   localparam int READ_IDX_W   = 9;
   // Byte counter covers the block, up to 255 wake bytes and the read index
   localparam int BYTE_IDX_W   = ($clog2(BLOCK_BYTES + 1) > READ_IDX_W) ?
                                 $clog2(BLOCK_BYTES + 1) : READ_IDX_W;

   // Configuration port
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAKE_BYTES = 1'd1;

   localparam logic [15:0] POLL_LIMIT_RESET = 16'hFFFF;
   localparam logic [7:0]  WAKE_BYTES_RESET = 8'd10;

   // Operation codes of the request, also stored as the operation kind
   localparam logic [1:0] OP_SLOT  = 2'd0;
   localparam logic [1:0] OP_INIT  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_WRITE = 2'd3;

   // Status codes
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_NO_IDLE      = 3'd1;
   localparam logic [2:0] ST_INIT_TIMEOUT = 3'd2;
   localparam logic [2:0] ST_CMD_REJECT   = 3'd3;
   localparam logic [2:0] ST_DATA_REJECT  = 3'd4;
   localparam logic [2:0] ST_TIMEOUT      = 3'd5;

   // Card protocol bytes
   localparam logic [7:0] CMD0_BYTE   = 8'h40;
   localparam logic [7:0] CMD1_BYTE   = 8'h41;
   localparam logic [7:0] CMD17_BYTE  = 8'h51;
   localparam logic [7:0] CMD24_BYTE  = 8'h58;
   localparam logic [7:0] CRC_BYTE    = 8'h95;
   localparam logic [7:0] TOKEN_BYTE  = 8'hFE;
   localparam logic [7:0] IDLE_BYTE   = 8'hFF;
   localparam logic [7:0] R1_IDLE     = 8'h01;
   localparam logic [7:0] DRESP_MASK  = 8'h05;
   localparam logic [BYTE_IDX_W-1:0] FRAME_LEN = BYTE_IDX_W'(6);
   localparam logic [BYTE_IDX_W-1:0] TAIL_LEN  = BYTE_IDX_W'(2);

   // Sequencer phases, one-hot
   typedef enum logic [18:0] {
      PH_IDLE        = 19'h00001,
      PH_WAKE        = 19'h00002,
      PH_FRAME0      = 19'h00004,
      PH_R1_0        = 19'h00008,
      PH_FLUSH_INIT  = 19'h00010,
      PH_FRAME       = 19'h00020,
      PH_R1          = 19'h00040,
      PH_TRAIL_OK    = 19'h00080,
      PH_TRAIL_RETRY = 19'h00100,
      PH_RD_FLUSH    = 19'h00200,
      PH_TOKEN       = 19'h00400,
      PH_RD_DATA     = 19'h00800,
      PH_CRC         = 19'h01000,
      PH_WR_FLUSH    = 19'h02000,
      PH_WR_TOKEN    = 19'h04000,
      PH_WR_DATA     = 19'h08000,
      PH_WR_FILL     = 19'h10000,
      PH_WR_RESP     = 19'h20000,
      PH_BUSY        = 19'h40000
   } phase_type;

   typedef struct packed {
      phase_type             phase;
      logic [1:0]            kind;
      logic [BYTE_IDX_W-1:0] byte_index;
      logic [15:0]           poll_count;
      logic [15:0]           attempt_count;
      logic [31:0]           address;
   } seq_state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] block_address;
      logic [7:0]  rx_byte;
      logic [7:0]  write_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0]            tx_byte;
      logic                  tx_valid;
      logic                  need_write_byte;
      logic [7:0]            read_byte;
      logic                  read_valid;
      logic [READ_IDX_W-1:0] read_index;
      logic                  done_res;
      logic [2:0]            status;
      logic                  busy_res;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] poll_limit;
      logic [7:0]  wake_bytes;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/sdspi_csr.sv =====
// ----------------------------------------------------------------------------
// sdspi_csr: configuration registers
// Holds the poll limit and the wake byte count, written through the csr port.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_csr
   import sdspi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Take a write at any time
   assign csr_ready = 1'b1;

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_POLL_LIMIT: cfg_in.poll_limit = csr_data[15:0];
            CSR_WAKE_BYTES: cfg_in.wake_bytes = csr_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.poll_limit <= POLL_LIMIT_RESET;
         cfg_ff.wake_bytes <= WAKE_BYTES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/sdspi_core.sv =====
// ----------------------------------------------------------------------------
// sdspi_core: sequencer step logic
// Computes the next sequencer state and the result of one transaction from
// the current state, the registered request and the configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module sdspi_core
   import sdspi_pkg::*;
(
   input  seq_state_type cur,
   input  req_item_type  item,
   input  cfg_type       cfg,
   output seq_state_type nxt,
   output rsp_item_type  rsp
);

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   logic [BYTE_IDX_W-1:0] idx_inc;
   logic [15:0]           poll_inc;
   logic                  poll_end;
   logic                  done;
   logic [2:0]            st;
   logic                  rvalid;
   logic [7:0]            cmd_byte;

   assign idx_inc  = cur.byte_index + BYTE_IDX_W'(1);
   assign poll_inc = sat_inc(cur.poll_count);
   assign poll_end = (poll_inc >= cfg.poll_limit);

   // Advance the phase
   always_comb begin
      nxt    = cur;
      done   = 1'b0;
      st     = ST_OK;
      rvalid = 1'b0;
      if (item.op != OP_SLOT) begin
         if (cur.phase == PH_IDLE) begin
            nxt.kind          = item.op;
            nxt.attempt_count = '0;
            nxt.byte_index    = '0;
            nxt.poll_count    = '0;
            if (item.op == OP_INIT) begin
               nxt.address = '0;
               nxt.phase   = PH_WAKE;
            end else begin
               nxt.address = item.block_address;
               nxt.phase   = PH_FRAME;
            end
         end
      end else begin
         case (cur.phase)
            PH_IDLE: nxt = cur;
            PH_WAKE: begin
               nxt.byte_index = idx_inc;
               if (idx_inc >= BYTE_IDX_W'(cfg.wake_bytes)) begin
                  nxt.phase      = PH_FRAME0;
                  nxt.byte_index = '0;
                  nxt.poll_count = '0;
               end
            end
            PH_FRAME0, PH_FRAME: begin
               nxt.byte_index = idx_inc;
               if (idx_inc >= FRAME_LEN) begin
                  nxt.phase      = (cur.phase == PH_FRAME0) ? PH_R1_0 : PH_R1;
                  nxt.byte_index = '0;
                  nxt.poll_count = '0;
               end
            end
            PH_R1_0: begin
               nxt.poll_count = poll_inc;
               if (!item.rx_byte[7] || poll_end) begin
                  if (item.rx_byte == R1_IDLE) begin
                     nxt.phase      = PH_FLUSH_INIT;
                     nxt.byte_index = '0;
                     nxt.poll_count = '0;
                  end else begin
                     done = 1'b1;
                     st   = ST_NO_IDLE;
                  end
               end
            end
            PH_FLUSH_INIT: begin
               nxt.phase      = PH_FRAME;
               nxt.byte_index = '0;
               nxt.poll_count = '0;
            end
            PH_R1: begin
               nxt.poll_count = poll_inc;
               if (!item.rx_byte[7] || poll_end) begin
                  if (cur.kind == OP_READ || cur.kind == OP_WRITE) begin
                     if (item.rx_byte != 8'd0) begin
                        done = 1'b1;
                        st   = ST_CMD_REJECT;
                     end else begin
                        nxt.phase = (cur.kind == OP_READ) ? PH_RD_FLUSH : PH_WR_FLUSH;
                        nxt.byte_index = '0;
                        nxt.poll_count = '0;
                     end
                  end else begin
                     nxt.attempt_count = sat_inc(cur.attempt_count);
                     nxt.phase = (item.rx_byte == 8'd0) ? PH_TRAIL_OK : PH_TRAIL_RETRY;
                     nxt.byte_index = '0;
                     nxt.poll_count = '0;
                  end
               end
            end
            PH_TRAIL_OK: done = 1'b1;
            PH_TRAIL_RETRY: begin
               if (cur.attempt_count >= cfg.poll_limit) begin
                  done = 1'b1;
                  st   = ST_INIT_TIMEOUT;
               end else begin
                  nxt.phase      = PH_FRAME;
                  nxt.byte_index = '0;
                  nxt.poll_count = '0;
               end
            end
            PH_RD_FLUSH: begin
               nxt.phase      = PH_TOKEN;
               nxt.byte_index = '0;
               nxt.poll_count = '0;
            end
            PH_TOKEN: begin
               nxt.poll_count = poll_inc;
               if (item.rx_byte == TOKEN_BYTE) begin
                  nxt.phase      = PH_RD_DATA;
                  nxt.byte_index = '0;
                  nxt.poll_count = '0;
               end else if (poll_end) begin
                  done = 1'b1;
                  st   = ST_TIMEOUT;
               end
            end
            PH_RD_DATA: begin
               rvalid         = 1'b1;
               nxt.byte_index = idx_inc;
               if (idx_inc >= BYTE_IDX_W'(BLOCK_BYTES)) begin
                  nxt.phase      = PH_CRC;
                  nxt.byte_index = '0;
                  nxt.poll_count = '0;
               end
            end
            PH_CRC: begin
               nxt.byte_index = idx_inc;
               if (idx_inc >= TAIL_LEN) begin
                  done = 1'b1;
               end
            end
            PH_WR_FLUSH: begin
               nxt.phase      = PH_WR_TOKEN;
               nxt.byte_index = '0;
               nxt.poll_count = '0;
            end
            PH_WR_TOKEN: begin
               nxt.phase      = PH_WR_DATA;
               nxt.byte_index = '0;
               nxt.poll_count = '0;
            end
            PH_WR_DATA: begin
               nxt.byte_index = idx_inc;
               if (idx_inc >= BYTE_IDX_W'(BLOCK_BYTES)) begin
                  nxt.phase      = PH_WR_FILL;
                  nxt.byte_index = '0;
                  nxt.poll_count = '0;
               end
            end
            PH_WR_FILL: begin
               nxt.byte_index = idx_inc;
               if (idx_inc >= TAIL_LEN) begin
                  nxt.phase      = PH_WR_RESP;
                  nxt.byte_index = '0;
                  nxt.poll_count = '0;
               end
            end
            PH_WR_RESP: begin
               if ((item.rx_byte & DRESP_MASK) != DRESP_MASK) begin
                  done = 1'b1;
                  st   = ST_DATA_REJECT;
               end else begin
                  nxt.phase      = PH_BUSY;
                  nxt.byte_index = '0;
                  nxt.poll_count = '0;
               end
            end
            PH_BUSY: begin
               nxt.poll_count = poll_inc;
               if (item.rx_byte == IDLE_BYTE) begin
                  done = 1'b1;
               end else if (poll_end) begin
                  done = 1'b1;
                  st   = ST_TIMEOUT;
               end
            end
            default: nxt.phase = PH_IDLE;
         endcase
         // Drop back to idle when the operation ends
         if (done) begin
            nxt.phase      = PH_IDLE;
            nxt.byte_index = '0;
            nxt.poll_count = '0;
         end
      end
   end

   // Pick the command byte of the running operation
   always_comb begin
      case (nxt.kind)
         OP_READ:  cmd_byte = CMD17_BYTE;
         OP_WRITE: cmd_byte = CMD24_BYTE;
         default:  cmd_byte = CMD1_BYTE;
      endcase
   end

   // Build the result from the updated state
   always_comb begin
      rsp = '0;
      case (nxt.phase)
         PH_IDLE: rsp.tx_byte = 8'd0;
         PH_FRAME0, PH_FRAME: begin
            case (nxt.byte_index)
               BYTE_IDX_W'(0): rsp.tx_byte = (nxt.phase == PH_FRAME0) ? CMD0_BYTE : cmd_byte;
               BYTE_IDX_W'(1): rsp.tx_byte = nxt.address[31:24];
               BYTE_IDX_W'(2): rsp.tx_byte = nxt.address[23:16];
               BYTE_IDX_W'(3): rsp.tx_byte = nxt.address[15:8];
               BYTE_IDX_W'(4): rsp.tx_byte = nxt.address[7:0];
               default:        rsp.tx_byte = CRC_BYTE;
            endcase
         end
         PH_WR_TOKEN: rsp.tx_byte = TOKEN_BYTE;
         PH_WR_DATA:  rsp.tx_byte = item.write_byte;
         default:     rsp.tx_byte = IDLE_BYTE;
      endcase
      rsp.tx_valid        = (nxt.phase != PH_IDLE);
      rsp.busy_res        = (nxt.phase != PH_IDLE);
      rsp.need_write_byte = (nxt.phase == PH_WR_TOKEN) ||
                            ((nxt.phase == PH_WR_DATA) &&
                             ((nxt.byte_index + BYTE_IDX_W'(1)) < BYTE_IDX_W'(BLOCK_BYTES)));
      rsp.read_valid      = rvalid;
      rsp.read_byte       = rvalid ? item.rx_byte : 8'd0;
      rsp.read_index      = rvalid ? cur.byte_index[READ_IDX_W-1:0] : '0;
      rsp.done_res        = done;
      rsp.status          = st;
   end

endmodule

`default_nettype wire

// ===== rtl/sd_spi_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_spi_command_sequencer: SD card SPI mode command sequencer
// Steps an SD card through init, block read and block write, one exchanged
// byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per SPI byte slot. op selects slot finished,
//            start init, start block read or start block write; rx_byte
//            carries the byte just received, write_byte the next data byte.
//   rsp_*  : one result per request: the next byte to send, read data with
//            its index, and done/status at the end of an operation.
//   csr_*  : writes poll_limit (index 0) and wake_bytes (index 1); always
//            ready; the user writes only while no operation is running (not enforced).
// A request is held in the request register, and its result in the result
// register. One request is taken every cycle while the result channel is not
// stalled; the rate is set by the combinational step logic between the request
// register and the result register. In use each transaction is one SPI byte exchange.
// Reset empties both registers, returns the sequencer to idle and restores
// poll_limit 65535 and wake_bytes 10. When rsp_ready is low the result holds,
// one more request is taken into the request register, then req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_command_sequencer
   import sdspi_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_op,
   input  wire logic [31:0]            req_block_address,
   input  wire logic [7:0]             req_rx_byte,
   input  wire logic [7:0]             req_write_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_tx_byte,
   output logic                        rsp_tx_valid,
   output logic                        rsp_need_write_byte,
   output logic [7:0]                  rsp_read_byte,
   output logic                        rsp_read_valid,
   output logic [READ_IDX_W-1:0]       rsp_read_index,
   output logic                        rsp_done_res,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_busy_res,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type       cfg;
   seq_state_type state_ff;
   seq_state_type state_nxt;
   req_item_type  req_ff;
   logic          req_valid_ff;
   logic          req_valid_in;
   rsp_item_type  rsp_ff;
   rsp_item_type  rsp_nxt;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          advance;

   sdspi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sdspi_core u_core (
      .cur  (state_ff),
      .item (req_ff),
      .cfg  (cfg),
      .nxt  (state_nxt),
      .rsp  (rsp_nxt)
   );

   // Move the held request into the result register when it is free
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   assign req_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff           <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         state_ff.phase         <= PH_IDLE;
         state_ff.kind          <= OP_SLOT;
         state_ff.byte_index    <= '0;
         state_ff.poll_count    <= '0;
         state_ff.attempt_count <= '0;
         state_ff.address       <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.op            <= req_op;
         req_ff.block_address <= req_block_address;
         req_ff.rx_byte       <= req_rx_byte;
         req_ff.write_byte    <= req_write_byte;
      end
      if (advance) begin
         rsp_ff <= rsp_nxt;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tx_byte         = rsp_ff.tx_byte;
   assign rsp_tx_valid        = rsp_ff.tx_valid;
   assign rsp_need_write_byte = rsp_ff.need_write_byte;
   assign rsp_read_byte       = rsp_ff.read_byte;
   assign rsp_read_valid      = rsp_ff.read_valid;
   assign rsp_read_index      = rsp_ff.read_index;
   assign rsp_done_res        = rsp_ff.done_res;
   assign rsp_status          = rsp_ff.status;
   assign rsp_busy_res        = rsp_ff.busy_res;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench of sd_spi_command_sequencer
// A simulated SD card answers every byte slot. A transaction-level tracker of the
// sequencer predicts each result, and the result channel is checked field by
// field. The run covers init, block read and block write, the failure and
// timeout paths, and several poll limit and wake byte settings.
// ----------------------------------------------------------------------------
module tb;
   import sdspi_pkg::*;

   // Track the sequencer state and hold the results it must produce
   class sequencer_tracker;
      logic [15:0]  poll_limit;
      logic [7:0]   wake_bytes;
      phase_type    phase;
      logic [1:0]   kind;
      logic [15:0]  byte_index;
      logic [15:0]  poll_count;
      logic [15:0]  attempt_count;
      logic [31:0]  address;
      rsp_item_type pending_rsp[$];
      int unsigned  errors;
      int unsigned  checked;

      function new();
         poll_limit    = POLL_LIMIT_RESET;
         wake_bytes    = WAKE_BYTES_RESET;
         phase         = PH_IDLE;
         kind          = OP_SLOT;
         byte_index    = '0;
         poll_count    = '0;
         attempt_count = '0;
         address       = '0;
         errors        = 0;
         checked       = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_POLL_LIMIT) begin
            poll_limit = data;
         end else begin
            wake_bytes = data[7:0];
         end
      endfunction

      function logic [15:0] sat_inc(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function void enter_phase(phase_type p);
         phase      = p;
         byte_index = '0;
         poll_count = '0;
      endfunction

      // Command frame: command, address MSB first, fixed CRC
      function logic [7:0] frame_byte(logic [7:0] cmd);
         logic [31:0] shifted;
         if (byte_index == 16'd0) return cmd;
         if (byte_index <= 16'd4) begin
            shifted = address >> (8 * (4 - byte_index));
            return shifted[7:0];
         end
         return CRC_BYTE;
      endfunction

      function logic [7:0] command_of_kind();
         if (kind == OP_READ) return CMD17_BYTE;
         if (kind == OP_WRITE) return CMD24_BYTE;
         return CMD1_BYTE;
      endfunction

      // Advance the sequencer by one transaction and return its result
      function rsp_item_type advance_sequencer(req_item_type r);
         rsp_item_type e;
         logic         done;
         logic [2:0]   st;
         e    = '0;
         done = 1'b0;
         st   = ST_OK;
         if (r.op != OP_SLOT) begin
            // starts count only while idle
            if (phase == PH_IDLE) begin
               kind          = r.op;
               attempt_count = '0;
               if (r.op == OP_INIT) begin
                  address = '0;
                  enter_phase(PH_WAKE);
               end else begin
                  address = r.block_address;
                  enter_phase(PH_FRAME);
               end
            end
         end else begin
            case (phase)
               PH_IDLE: ;
               PH_WAKE: begin
                  byte_index = sat_inc(byte_index);
                  if (byte_index >= {8'd0, wake_bytes}) enter_phase(PH_FRAME0);
               end
               PH_FRAME0, PH_FRAME: begin
                  byte_index = sat_inc(byte_index);
                  if (byte_index >= 16'(FRAME_LEN))
                     enter_phase(phase == PH_FRAME0 ? PH_R1_0 : PH_R1);
               end
               PH_R1_0: begin
                  poll_count = sat_inc(poll_count);
                  if (!r.rx_byte[7] || poll_count >= poll_limit) begin
                     if (r.rx_byte == R1_IDLE) begin
                        enter_phase(PH_FLUSH_INIT);
                     end else begin
                        done = 1'b1;
                        st   = ST_NO_IDLE;
                     end
                  end
               end
               PH_FLUSH_INIT: enter_phase(PH_FRAME);
               PH_R1: begin
                  poll_count = sat_inc(poll_count);
                  if (!r.rx_byte[7] || poll_count >= poll_limit) begin
                     if (kind == OP_READ || kind == OP_WRITE) begin
                        if (r.rx_byte != 8'd0) begin
                           done = 1'b1;
                           st   = ST_CMD_REJECT;
                        end else begin
                           enter_phase(kind == OP_READ ? PH_RD_FLUSH : PH_WR_FLUSH);
                        end
                     end else begin
                        attempt_count = sat_inc(attempt_count);
                        enter_phase(r.rx_byte == 8'd0 ? PH_TRAIL_OK : PH_TRAIL_RETRY);
                     end
                  end
               end
               PH_TRAIL_OK: done = 1'b1;
               PH_TRAIL_RETRY: begin
                  if (attempt_count >= poll_limit) begin
                     done = 1'b1;
                     st   = ST_INIT_TIMEOUT;
                  end else begin
                     enter_phase(PH_FRAME);
                  end
               end
               PH_RD_FLUSH: enter_phase(PH_TOKEN);
               PH_TOKEN: begin
                  poll_count = sat_inc(poll_count);
                  if (r.rx_byte == TOKEN_BYTE) begin
                     enter_phase(PH_RD_DATA);
                  end else if (poll_count >= poll_limit) begin
                     done = 1'b1;
                     st   = ST_TIMEOUT;
                  end
               end
               PH_RD_DATA: begin
                  e.read_valid = 1'b1;
                  e.read_byte  = r.rx_byte;
                  e.read_index = byte_index[READ_IDX_W-1:0];
                  byte_index   = sat_inc(byte_index);
                  if (byte_index >= 16'(BLOCK_BYTES)) enter_phase(PH_CRC);
               end
               PH_CRC: begin
                  byte_index = sat_inc(byte_index);
                  if (byte_index >= 16'(TAIL_LEN)) done = 1'b1;
               end
               PH_WR_FLUSH: enter_phase(PH_WR_TOKEN);
               PH_WR_TOKEN: enter_phase(PH_WR_DATA);
               PH_WR_DATA: begin
                  byte_index = sat_inc(byte_index);
                  if (byte_index >= 16'(BLOCK_BYTES)) enter_phase(PH_WR_FILL);
               end
               PH_WR_FILL: begin
                  byte_index = sat_inc(byte_index);
                  if (byte_index >= 16'(TAIL_LEN)) enter_phase(PH_WR_RESP);
               end
               PH_WR_RESP: begin
                  if ((r.rx_byte & DRESP_MASK) != DRESP_MASK) begin
                     done = 1'b1;
                     st   = ST_DATA_REJECT;
                  end else begin
                     enter_phase(PH_BUSY);
                  end
               end
               PH_BUSY: begin
                  poll_count = sat_inc(poll_count);
                  if (r.rx_byte == IDLE_BYTE) begin
                     done = 1'b1;
                  end else if (poll_count >= poll_limit) begin
                     done = 1'b1;
                     st   = ST_TIMEOUT;
                  end
               end
               default: phase = PH_IDLE;
            endcase
            if (done) enter_phase(PH_IDLE);
         end

         // next byte to shift out
         case (phase)
            PH_IDLE:     e.tx_byte = 8'd0;
            PH_FRAME0:   e.tx_byte = frame_byte(CMD0_BYTE);
            PH_FRAME:    e.tx_byte = frame_byte(command_of_kind());
            PH_WR_TOKEN: e.tx_byte = TOKEN_BYTE;
            PH_WR_DATA:  e.tx_byte = r.write_byte;
            default:     e.tx_byte = IDLE_BYTE;
         endcase
         e.tx_valid        = (phase != PH_IDLE);
         e.need_write_byte = (phase == PH_WR_TOKEN) ||
                             (phase == PH_WR_DATA &&
                              {16'd0, byte_index} + 32'd1 < 32'(BLOCK_BYTES));
         e.done_res        = done;
         e.status          = st;
         e.busy_res        = (phase != PH_IDLE);
         return e;
      endfunction

      function void take_request(req_item_type r);
         pending_rsp.push_back(advance_sequencer(r));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= 100)
               $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
         end
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: result with no transaction outstanding, expected none actual tx 0x%0h",
                     $time, got.tx_byte);
            return;
         end
         want = pending_rsp.pop_front();
         checked++;
         compare_field("tx_byte", want.tx_byte, got.tx_byte);
         compare_field("tx_valid", want.tx_valid, got.tx_valid);
         compare_field("need_write_byte", want.need_write_byte, got.need_write_byte);
         compare_field("read_byte", want.read_byte, got.read_byte);
         compare_field("read_valid", want.read_valid, got.read_valid);
         compare_field("read_index", want.read_index, got.read_index);
         compare_field("done_res", want.done_res, got.done_res);
         compare_field("status", want.status, got.status);
         compare_field("busy_res", want.busy_res, got.busy_res);
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_op = OP_SLOT;
   logic [31:0]            req_block_address = '0;
   logic [7:0]             req_rx_byte = '0;
   logic [7:0]             req_write_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_tx_byte;
   logic                   rsp_tx_valid;
   logic                   rsp_need_write_byte;
   logic [7:0]             rsp_read_byte;
   logic                   rsp_read_valid;
   logic [READ_IDX_W-1:0]  rsp_read_index;
   logic                   rsp_done_res;
   logic [2:0]             rsp_status;
   logic                   rsp_busy_res;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_POLL_LIMIT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   sequencer_tracker tracker = new();
   logic [7:0]       scripted_rx[$];
   rsp_item_type     seen_rsp;
   bit               gaps_on = 1'b1;
   int unsigned      gap_odds = 4;
   int unsigned      stall_left = 0;
   int unsigned      items_sent = 0;
   int unsigned      ops_run = 0;
   int unsigned      blocks_read = 0;
   int unsigned      blocks_written = 0;

   sd_spi_command_sequencer u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_block_address   (req_block_address),
      .req_rx_byte         (req_rx_byte),
      .req_write_byte      (req_write_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_need_write_byte (rsp_need_write_byte),
      .rsp_read_byte       (rsp_read_byte),
      .rsp_read_valid      (rsp_read_valid),
      .rsp_read_index      (rsp_read_index),
      .rsp_done_res        (rsp_done_res),
      .rsp_status          (rsp_status),
      .rsp_busy_res        (rsp_busy_res),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Check accepted results and stall the result channel in bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_rsp.tx_byte         = rsp_tx_byte;
         seen_rsp.tx_valid        = rsp_tx_valid;
         seen_rsp.need_write_byte = rsp_need_write_byte;
         seen_rsp.read_byte       = rsp_read_byte;
         seen_rsp.read_valid      = rsp_read_valid;
         seen_rsp.read_index      = rsp_read_index;
         seen_rsp.done_res        = rsp_done_res;
         seen_rsp.status          = rsp_status;
         seen_rsp.busy_res        = rsp_busy_res;
         tracker.check_response(seen_rsp);
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, gap_odds) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Drive one request transaction, holding it until accepted
   task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                            input logic [7:0] rx, input logic [7:0] wbyte);
      req_item_type item;
      item.op            = op;
      item.block_address = addr;
      item.rx_byte       = rx;
      item.write_byte    = wbyte;
      if (gaps_on && $urandom_range(0, gap_odds) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_block_address <= addr;
      req_rx_byte       <= rx;
      req_write_byte    <= wbyte;
      do @(posedge clock); while (!req_ready);
      tracker.take_request(item);
      items_sent++;
   endtask

   // Drop valid, drain all outstanding results, then let the pipeline settle
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers back to back while the sequencer is idle
   task automatic program_settings(input logic [15:0] limit, input logic [15:0] wake_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_POLL_LIMIT;
      csr_data  <= limit;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(CSR_POLL_LIMIT, limit);
      csr_index <= CSR_WAKE_BYTES;
      csr_data  <= wake_word;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(CSR_WAKE_BYTES, wake_word);
      csr_valid <= 1'b0;
   endtask

   // Card answer for the slot just run, shaped by the phase being polled
   function automatic logic [7:0] card_answer();
      int unsigned pick;
      logic [7:0]  any;
      pick = $urandom_range(0, 9);
      any  = 8'($urandom);
      if (scripted_rx.size() != 0) return scripted_rx.pop_front();
      case (tracker.phase)
         PH_R1_0: begin
            if (pick < 5) return any | 8'h80;
            if (pick < 9) return R1_IDLE;
            return any & 8'h7F;
         end
         PH_R1: begin
            if (pick < 4) return any | 8'h80;
            if (tracker.kind == OP_INIT) return (pick < 7) ? R1_IDLE : 8'h00;
            // accept data commands until one full block has moved each way
            if (pick < 5 && ((tracker.kind == OP_READ) ? (blocks_read == 0) :
                             (blocks_written == 0)))
               return 8'h00;
            return (any & 8'h7F) | 8'h04;
         end
         PH_TOKEN: begin
            if (pick < 5) return IDLE_BYTE;
            if (pick < 9) return TOKEN_BYTE;
            return any;
         end
         PH_WR_RESP: begin
            if (pick < 5) return (any & 8'hE0) | DRESP_MASK;
            if (pick < 8) return any | DRESP_MASK;
            return any;
         end
         PH_BUSY: return (pick < 6) ? (any & 8'hFE) : IDLE_BYTE;
         default: return any;
      endcase
   endfunction

   // Start one operation and answer its slots until it ends
   task automatic run_op(input logic [1:0] op, input logic [31:0] addr);
      phase_type prior_phase;
      send_item(op, addr, 8'($urandom), 8'($urandom));
      ops_run++;
      while (tracker.phase != PH_IDLE) begin
         prior_phase = tracker.phase;
         if ($urandom_range(0, 15) == 0) begin
            // stray start while busy must be ignored
            send_item(2'($urandom_range(1, 3)), $urandom, 8'($urandom), 8'($urandom));
         end else begin
            send_item(OP_SLOT, $urandom, card_answer(), 8'($urandom));
         end
         if (tracker.phase == PH_CRC && prior_phase != PH_CRC) blocks_read++;
         if (tracker.phase == PH_WR_FILL && prior_phase != PH_WR_FILL) blocks_written++;
      end
   endtask

   initial begin
      logic [15:0] limit_set[6];
      logic [7:0]  wake_set[6];
      int unsigned phase_start;
      int unsigned pick;
      logic [1:0]  op;

      limit_set = '{16'hFFFF, 16'd1, 16'd2, 16'd3, 16'($urandom_range(4, 20)), 16'hFFFF};
      wake_set  = '{8'd10, 8'd1, 8'd255, 8'd3, 8'($urandom_range(1, 20)), 8'd10};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: slot item while idle gives an all-zero result
      send_item(OP_SLOT, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      settle();

      // Directed: zero limits act as one
      program_settings(16'h0000, 16'hFF00);

      // Init, stray starts while busy, no idle answer on the only poll
      send_item(OP_INIT, 32'hFFFF_FFFF, 8'h00, 8'h00);
      send_item(OP_READ, 32'h1234_5678, 8'hFF, 8'hFF);
      send_item(OP_WRITE, 32'h8765_4321, 8'h00, 8'hFF);
      repeat (7) scripted_rx.push_back(8'($urandom));
      scripted_rx.push_back(8'hFF);
      while (tracker.phase != PH_IDLE) send_item(OP_SLOT, 32'h0, card_answer(), 8'h00);

      // Read at all-ones address, token timeout on the single poll
      repeat (6) scripted_rx.push_back(8'($urandom));
      scripted_rx.push_back(8'h00);
      scripted_rx.push_back(8'($urandom));
      scripted_rx.push_back(8'h00);
      run_op(OP_READ, 32'hFFFF_FFFF);

      // Write at address zero, command rejected
      repeat (6) scripted_rx.push_back(8'($urandom));
      scripted_rx.push_back(8'h04);
      run_op(OP_WRITE, 32'h0000_0000);

      // Random operations across register settings; the last one runs without gaps
      for (int s = 0; s < 6; s++) begin
         settle();
         program_settings(limit_set[s], {8'($urandom), wake_set[s]});
         gaps_on     = (s != 5);
         gap_odds    = $urandom_range(3, 8);
         phase_start = items_sent;
         while (items_sent - phase_start < ((s == 5) ? 30 : 10) ||
                (s == 5 && (blocks_read == 0 || blocks_written == 0))) begin
            if ($urandom_range(0, 4) == 0)
               send_item(OP_SLOT, $urandom, 8'($urandom), 8'($urandom));
            pick = $urandom_range(0, 9);
            op   = (pick < 4) ? OP_INIT : (pick < 7) ? OP_READ : OP_WRITE;
            run_op(op, $urandom);
         end
      end

      settle();
      $display("covered %0d transactions in %0d operations, %0d results checked",
               items_sent, ops_run, tracker.checked);
      $display("full data blocks: %0d read, %0d written", blocks_read, blocks_written);
      if (tracker.errors == 0 && tracker.pending_rsp.size() == 0) begin
         $display("sd_spi_command_sequencer: match");
      end else begin
         $display("sd_spi_command_sequencer: mismatch");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #6_000_000;
      $display("sd_spi_command_sequencer: mismatch");
      $finish;
   end

endmodule

// ===== sd_spi_command_sequencer.f =====
rtl/sdspi_pkg.sv
rtl/sdspi_csr.sv
rtl/sdspi_core.sv
rtl/sd_spi_command_sequencer.sv
test/tb.sv
